// ===== src/dvd_pkg.sv =====
// Package for the duplicate value detector.
// Holds sizing constants, mark codes and the controller state type.
// No dependencies.
`default_nettype none
package dvd_pkg;
   localparam int VALUE_RANGE = 1024;
   localparam int VALUE_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int ADDR_W      = $clog2(VALUE_RANGE);
   localparam int MARK_W      = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(VALUE_RANGE - 1);

   localparam logic [MARK_W-1:0] MARK_UNSEEN   = 2'd0;
   localparam logic [MARK_W-1:0] MARK_ONCE     = 2'd1;
   localparam logic [MARK_W-1:0] MARK_REPORTED = 2'd2;

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_END = 1'b1;

   localparam logic KIND_DUP     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;
endpackage
`default_nettype wire

// ===== src/dvd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds when rd_en is low. No dependencies.
`default_nettype none
module dvd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/duplicate_value_detector.sv =====
// Top level of the duplicate value detector.
// Uses dvd_pkg and one dvd_ram instance for the mark table.
//
// Value requests are taken at one per cycle while req_stall is low: each reads its mark
// from the RAM, and stage s1 then modifies and writes it back, with forwarding when two
// consecutive requests hit the same value. An end-of-set request blocks the input while
// it is processed, then the mark table is cleared one entry a cycle over all VALUE_RANGE
// (1024) entries, during which req_stall is high. The same clearing pass runs after reset.
// The summary response is issued as the clearing pass starts.
`default_nettype none
module duplicate_value_detector
   import dvd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_kind,
   output logic      [VALUE_W-1:0] rsp_dup_value,
   output logic                    rsp_any_found,
   output logic      [COUNT_W-1:0] rsp_dup_count
);
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_action_ff;
   logic               s1_inrange_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic               s1_fwd_ff, s1_fwd_in;
   logic [MARK_W-1:0]  s1_fwd_mark_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_any_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               accept, out_free, s1_fire, s1_wr, s1_res;
   logic [ADDR_W-1:0]  s1_addr, req_addr;
   logic [MARK_W-1:0]  rd_mark, mark_cur, mark_new;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [MARK_W-1:0]  ram_wr_data;

   dvd_ram #(
      .WIDTH(MARK_W),
      .DEPTH(VALUE_RANGE)
   ) u_mark_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (accept),
      .rd_addr(req_addr),
      .rd_data(rd_mark)
   );

   assign req_addr = ADDR_W'(req_value);
   assign s1_addr  = ADDR_W'(s1_value_ff);

   always_comb begin
      mark_cur = s1_fwd_ff ? s1_fwd_mark_ff : rd_mark;
      mark_new = (mark_cur == MARK_UNSEEN) ? MARK_ONCE : MARK_REPORTED;
      s1_wr    = s1_valid_ff && (s1_action_ff == ACT_ADD) && s1_inrange_ff &&
                 ((mark_cur == MARK_UNSEEN) || (mark_cur == MARK_ONCE));
      s1_res   = s1_valid_ff && ((s1_action_ff == ACT_END) ||
                 (s1_inrange_ff && (mark_cur == MARK_ONCE)));
      out_free = !rsp_valid_ff || !rsp_stall;
      s1_fire  = s1_valid_ff && out_free;

      req_stall = !((state_ff == ST_RUN) &&
                    !(s1_valid_ff && (s1_action_ff == ACT_END)) &&
                    (!s1_valid_ff || s1_fire));
      accept    = req_valid && !req_stall;

      ram_wr_en   = (state_ff == ST_CLEAR) || (s1_fire && s1_wr);
      ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : s1_addr;
      ram_wr_data = (state_ff == ST_CLEAR) ? MARK_UNSEEN : mark_new;

      s1_fwd_in   = s1_fire && s1_wr && (s1_addr == req_addr);
      s1_valid_in = accept || (s1_valid_ff && !s1_fire);

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || (s1_fire && s1_res);

      count_in = count_ff;
      if (s1_fire) begin
         if (s1_action_ff == ACT_END) begin
            count_in = '0;
         end else if (s1_res && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
      end

      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clr_addr_in = '0;
            if (s1_fire && (s1_action_ff == ACT_END)) begin
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in    = ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff   <= req_action;
         s1_value_ff    <= req_value;
         s1_inrange_ff  <= (32'(req_value) < VALUE_RANGE);
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_mark_ff <= mark_new;
      end
      if (s1_fire && s1_res) begin
         if (s1_action_ff == ACT_END) begin
            rsp_kind_ff  <= KIND_SUMMARY;
            rsp_value_ff <= '0;
            rsp_any_ff   <= (count_ff != '0);
            rsp_count_ff <= count_ff;
         end else begin
            rsp_kind_ff  <= KIND_DUP;
            rsp_value_ff <= s1_value_ff;
            rsp_any_ff   <= 1'b0;
            rsp_count_ff <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_dup_value = rsp_value_ff;
   assign rsp_any_found = rsp_any_ff;
   assign rsp_dup_count = rsp_count_ff;
endmodule
`default_nettype wire
